>>> hdl/pl0_token_scanner_macros.svh
`ifndef PL0_TOKEN_SCANNER_MACROS_SVH
`define PL0_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, off while reset is high
`define PL0TS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define PL0TS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/pl0ts_pkg.sv
`default_nettype none
package pl0ts_pkg;

   localparam int NAME_CHARS_DEF    = 13;
   localparam int NUMBER_DIGITS_DEF = 5;

   // characters kept per word, fixed by the name output fields
   localparam int BUF_CHARS     = 13;
   localparam int NAME_LO_CHARS = 8;
   localparam int CH_IDX_W      = $clog2(BUF_CHARS);
   // word length saturates one above the cap set here
   localparam int WORD_LEN_CAP  = 16;
   localparam int WLEN_W        = 5;

   // queue depths, powers of two
   localparam int FQ_DEPTH = 2;
   localparam int RQ_DEPTH = 4;

   // token kinds
   localparam logic [5:0] TK_END     = 6'd0;
   localparam logic [5:0] TK_IDENT   = 6'd14;
   localparam logic [5:0] TK_NUMBER  = 6'd15;
   localparam logic [5:0] TK_BECOMES = 6'd16;
   localparam logic [5:0] TK_PLUS    = 6'd17;
   localparam logic [5:0] TK_MINUS   = 6'd18;
   localparam logic [5:0] TK_TIMES   = 6'd19;
   localparam logic [5:0] TK_SLASH   = 6'd20;
   localparam logic [5:0] TK_MOD     = 6'd21;
   localparam logic [5:0] TK_EQL     = 6'd22;
   localparam logic [5:0] TK_NEQ     = 6'd23;
   localparam logic [5:0] TK_LSS     = 6'd24;
   localparam logic [5:0] TK_LEQ     = 6'd25;
   localparam logic [5:0] TK_GTR     = 6'd26;
   localparam logic [5:0] TK_GEQ     = 6'd27;
   localparam logic [5:0] TK_LPAREN  = 6'd29;
   localparam logic [5:0] TK_RPAREN  = 6'd30;
   localparam logic [5:0] TK_COMMA   = 6'd31;
   localparam logic [5:0] TK_PERIOD  = 6'd32;
   localparam logic [5:0] TK_SEMI    = 6'd33;

   // error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_SYMBOL  = 3'd1;
   localparam logic [2:0] ERR_BAD_IDENT   = 3'd2;
   localparam logic [2:0] ERR_LONG_NUMBER = 3'd3;
   localparam logic [2:0] ERR_LONG_IDENT  = 3'd4;

   // characters
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_PERIOD = 8'h2e;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_COLON  = 8'h3a;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_LT     = 8'h3c;
   localparam logic [7:0] CH_EQ     = 8'h3d;
   localparam logic [7:0] CH_GT     = 8'h3e;

   // keywords, text stored reversed so the first char sits in the low byte
   localparam int KW_COUNT   = 14;
   localparam int KW_MAX_LEN = 9;
   localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
      72'("tsnoc"), 72'("rav"), 72'("erudecorp"), 72'("nigeb"), 72'("dne"),
      72'("elihw"), 72'("od"), 72'("fi"), 72'("neht"), 72'("esle"),
      72'("llac"), 72'("etirw"), 72'("daer"), 72'("ddo")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd3, 4'd9, 4'd5, 4'd3, 4'd5, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd3
   };
   localparam logic [5:0] KW_CODE [KW_COUNT] = '{
      6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13,
      6'd28
   };

   typedef struct packed {
      logic is_nul;
      logic is_digit;
      logic is_alpha;
      logic is_punct;
   } byte_cls_type;

   typedef struct packed {
      logic [7:0]   text_byte;
      byte_cls_type cls;
   } fq_item_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [16:0] num;
      logic [63:0] lo;
      logic [39:0] hi;
      logic [3:0]  len;
      logic        last;
   } rsp_rec_type;

   typedef struct packed {
      logic [1:0]  cnt;
      rsp_rec_type rec0;
      rsp_rec_type rec1;
   } rspq_push_type;

   function automatic byte_cls_type classify(input logic [7:0] b);
      byte_cls_type c;
      c.is_nul   = (b == 8'd0);
      c.is_digit = b inside {[8'h30:8'h39]};
      c.is_alpha = b inside {[8'h41:8'h5a], [8'h61:8'h7a]};
      c.is_punct = b inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]};
      return c;
   endfunction

   // parallel compare against all keywords, zero when none matches
   function automatic logic [5:0] kw_lookup(input logic [BUF_CHARS*8-1:0] chars,
                                            input logic [WLEN_W-1:0] wlen);
      logic [5:0] code;
      logic       hit;
      code = 6'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (wlen == {1'b0, KW_LEN[k]});
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (4'(i) < KW_LEN[k] && chars[i*8 +: 8] != KW_TEXT[k][i*8 +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            code = KW_CODE[k];
         end
      end
      return code;
   endfunction

endpackage
`default_nettype wire

>>> hdl/pl0ts_front.sv
`default_nettype none
module pl0ts_front import pl0ts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   input  wire logic [7:0]  req_text_byte,
   output logic             req_full,
   input  wire logic        item_take,
   output logic             item_valid,
   output fq_item_type      item
);

   localparam int PTR_W = $clog2(FQ_DEPTH);
   localparam int CNT_W = $clog2(FQ_DEPTH + 1);

   fq_item_type      ent_ff [FQ_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push_ok, pop_ok;

   assign req_full   = (cnt_ff == CNT_W'(FQ_DEPTH));
   assign item_valid = (cnt_ff != '0);
   assign item       = ent_ff[rd_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   always_comb begin
      wr_in  = wr_ff + PTR_W'(push_ok);
      rd_in  = rd_ff + PTR_W'(pop_ok);
      cnt_in = cnt_ff + CNT_W'(push_ok) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // class bits are worked out once, on the way in
   always_ff @(posedge clock) begin
      if (push_ok) begin
         ent_ff[wr_ff] <= '{text_byte: req_text_byte, cls: classify(req_text_byte)};
      end
   end

endmodule
`default_nettype wire

>>> hdl/pl0ts_back.sv
`default_nettype none
module pl0ts_back import pl0ts_pkg::*; #(
   parameter int NAME_CHARS    = NAME_CHARS_DEF,
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         item_valid,
   input  wire fq_item_type  item,
   output logic              item_take,
   input  wire logic         rq_room,
   output rspq_push_type     rq_push
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_WORD    = 6'b000010,
      ST_PEND    = 6'b000100,
      ST_SLASH   = 6'b001000,
      ST_COMMENT = 6'b010000,
      ST_HALT    = 6'b100000
   } scan_state_type;

   scan_state_type      mode_ff, mode_in;
   logic [7:0]          chars_ff [BUF_CHARS];
   logic [WLEN_W-1:0]   wlen_ff, wlen_in;
   logic [16:0]         accum_ff, accum_in;
   logic [7:0]          pend_ff, pend_in;
   logic                digit_ff, digit_in;

   logic                ch_we;
   logic [CH_IDX_W-1:0] ch_idx;
   logic [7:0]          b;
   byte_cls_type        cls;
   logic                alnum;
   logic [BUF_CHARS*8-1:0] chars_vec;
   logic [5:0]          kw_code;
   logic [63:0]         name_lo;
   logic [39:0]         name_hi;
   rsp_rec_type         res_v [2];
   logic [1:0]          n_v;
   logic                do_start, fail_v;
   logic [2:0]          fail_err;
   logic [5:0]          pend_kind;

   function automatic rsp_rec_type mk_rec(input logic [5:0] kind, input logic [2:0] err);
      rsp_rec_type r;
      r      = '0;
      r.kind = kind;
      r.err  = err;
      return r;
   endfunction

   assign item_take = item_valid && rq_room;
   assign b         = item.text_byte;
   assign cls       = item.cls;
   assign alnum     = cls.is_digit || cls.is_alpha;

   always_comb begin
      for (int k = 0; k < BUF_CHARS; k++) begin
         chars_vec[k*8 +: 8] = chars_ff[k];
      end
      for (int k = 0; k < NAME_LO_CHARS; k++) begin
         name_lo[k*8 +: 8] = (WLEN_W'(k) < wlen_ff) ? chars_ff[k] : 8'd0;
      end
      for (int k = NAME_LO_CHARS; k < BUF_CHARS; k++) begin
         name_hi[(k-NAME_LO_CHARS)*8 +: 8] = (WLEN_W'(k) < wlen_ff) ? chars_ff[k] : 8'd0;
      end
   end

   assign kw_code = kw_lookup(chars_vec, wlen_ff);

   always_comb begin
      case (pend_ff)
         CH_COLON: pend_kind = TK_BECOMES;
         CH_EQ:    pend_kind = TK_EQL;
         CH_BANG:  pend_kind = TK_NEQ;
         CH_LT:    pend_kind = TK_LEQ;
         default:  pend_kind = TK_GEQ;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      wlen_in  = wlen_ff;
      accum_in = accum_ff;
      pend_in  = pend_ff;
      digit_in = digit_ff;
      ch_we    = 1'b0;
      ch_idx   = wlen_ff[CH_IDX_W-1:0];
      res_v[0] = mk_rec(TK_END, ERR_NONE);
      res_v[1] = mk_rec(TK_END, ERR_NONE);
      n_v      = 2'd0;
      do_start = 1'b0;
      fail_v   = 1'b0;
      fail_err = ERR_NONE;

      case (mode_ff)
         ST_HALT: begin
            if (cls.is_nul) begin
               res_v[n_v[0]] = mk_rec(TK_END, ERR_NONE);
               n_v = n_v + 2'd1;
               mode_in = ST_IDLE;
            end
         end
         ST_COMMENT: begin
            if (cls.is_nul) begin
               res_v[n_v[0]] = mk_rec(TK_END, ERR_NONE);
               n_v = n_v + 2'd1;
               mode_in = ST_IDLE;
            end else if (b == CH_LF) begin
               mode_in = ST_IDLE;
            end
         end
         ST_SLASH: begin
            if (b == CH_SLASH) begin
               mode_in = ST_COMMENT;
            end else begin
               res_v[n_v[0]] = mk_rec(TK_SLASH, ERR_NONE);
               n_v = n_v + 2'd1;
               do_start = 1'b1;
            end
         end
         ST_PEND: begin
            if (b == CH_EQ) begin
               res_v[n_v[0]] = mk_rec(pend_kind, ERR_NONE);
               n_v = n_v + 2'd1;
               mode_in = ST_IDLE;
            end else if (pend_ff == CH_LT || pend_ff == CH_GT) begin
               res_v[n_v[0]] = mk_rec((pend_ff == CH_LT) ? TK_LSS : TK_GTR, ERR_NONE);
               n_v = n_v + 2'd1;
               do_start = 1'b1;
            end else begin
               fail_v   = 1'b1;
               fail_err = ERR_BAD_SYMBOL;
            end
         end
         ST_WORD: begin
            if (alnum) begin
               if (digit_ff) begin
                  if (wlen_ff >= WLEN_W'(NUMBER_DIGITS)) begin
                     fail_v   = 1'b1;
                     fail_err = ERR_LONG_NUMBER;
                  end else if (cls.is_alpha) begin
                     fail_v   = 1'b1;
                     fail_err = ERR_BAD_IDENT;
                  end else begin
                     // times ten as two shifts, wraps at 17 bits
                     accum_in = {accum_ff[13:0], 3'b000} + {accum_ff[15:0], 1'b0}
                              + {9'd0, b - CH_0};
                     wlen_in  = wlen_ff + 1'b1;
                  end
               end else begin
                  if (wlen_ff < WLEN_W'(BUF_CHARS)) begin
                     ch_we = 1'b1;
                  end
                  if (wlen_ff <= WLEN_W'(WORD_LEN_CAP)) begin
                     wlen_in = wlen_ff + 1'b1;
                  end
               end
            end else begin
               mode_in = ST_IDLE;
               if (digit_ff) begin
                  res_v[n_v[0]] = mk_rec(TK_NUMBER, ERR_NONE);
                  res_v[n_v[0]].num = accum_ff;
                  n_v = n_v + 2'd1;
                  do_start = 1'b1;
               end else if (kw_code != 6'd0) begin
                  res_v[n_v[0]] = mk_rec(kw_code, ERR_NONE);
                  n_v = n_v + 2'd1;
                  do_start = 1'b1;
               end else if (wlen_ff > WLEN_W'(NAME_CHARS) ||
                            wlen_ff > WLEN_W'(WORD_LEN_CAP)) begin
                  fail_v   = 1'b1;
                  fail_err = ERR_LONG_IDENT;
               end else begin
                  res_v[n_v[0]] = mk_rec(TK_IDENT, ERR_NONE);
                  res_v[n_v[0]].lo  = name_lo;
                  res_v[n_v[0]].hi  = name_hi;
                  res_v[n_v[0]].len = wlen_ff[3:0];
                  n_v = n_v + 2'd1;
                  do_start = 1'b1;
               end
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase

      // scan the byte as the first of a new token
      if (do_start) begin
         mode_in = ST_IDLE;
         if (cls.is_nul) begin
            res_v[n_v[0]] = mk_rec(TK_END, ERR_NONE);
            n_v = n_v + 2'd1;
         end else if (alnum) begin
            ch_we    = 1'b1;
            ch_idx   = '0;
            wlen_in  = WLEN_W'(1);
            digit_in = cls.is_digit;
            accum_in = cls.is_digit ? {9'd0, b - CH_0} : 17'd0;
            mode_in  = ST_WORD;
         end else if (cls.is_punct) begin
            case (b)
               CH_EQ, CH_LT, CH_GT, CH_COLON, CH_BANG: begin
                  pend_in = b;
                  mode_in = ST_PEND;
               end
               CH_SLASH: mode_in = ST_SLASH;
               CH_PLUS, CH_MINUS, CH_STAR, CH_PCT, CH_LPAREN, CH_RPAREN, CH_COMMA,
               CH_PERIOD, CH_SEMI: begin
                  case (b)
                     CH_PLUS:   res_v[n_v[0]] = mk_rec(TK_PLUS, ERR_NONE);
                     CH_MINUS:  res_v[n_v[0]] = mk_rec(TK_MINUS, ERR_NONE);
                     CH_STAR:   res_v[n_v[0]] = mk_rec(TK_TIMES, ERR_NONE);
                     CH_PCT:    res_v[n_v[0]] = mk_rec(TK_MOD, ERR_NONE);
                     CH_LPAREN: res_v[n_v[0]] = mk_rec(TK_LPAREN, ERR_NONE);
                     CH_RPAREN: res_v[n_v[0]] = mk_rec(TK_RPAREN, ERR_NONE);
                     CH_COMMA:  res_v[n_v[0]] = mk_rec(TK_COMMA, ERR_NONE);
                     CH_PERIOD: res_v[n_v[0]] = mk_rec(TK_PERIOD, ERR_NONE);
                     default:   res_v[n_v[0]] = mk_rec(TK_SEMI, ERR_NONE);
                  endcase
                  n_v = n_v + 2'd1;
               end
               default: begin
                  fail_v   = 1'b1;
                  fail_err = ERR_BAD_SYMBOL;
               end
            endcase
         end
      end

      // a waiting symbol is always dropped, even one just set again
      if (mode_ff == ST_PEND) begin
         pend_in = 8'd0;
      end

      if (fail_v) begin
         res_v[n_v[0]] = mk_rec(TK_END, fail_err);
         n_v = n_v + 2'd1;
         mode_in = ST_HALT;
         if (cls.is_nul) begin
            res_v[n_v[0]] = mk_rec(TK_END, ERR_NONE);
            n_v = n_v + 2'd1;
            mode_in = ST_IDLE;
         end
      end

      if (n_v == 2'd1) begin
         res_v[0].last = 1'b1;
      end else if (n_v == 2'd2) begin
         res_v[1].last = 1'b1;
      end
   end

   always_comb begin
      rq_push.cnt  = item_take ? n_v : 2'd0;
      rq_push.rec0 = res_v[0];
      rq_push.rec1 = res_v[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ST_IDLE;
         wlen_ff  <= '0;
         accum_ff <= '0;
         pend_ff  <= '0;
         digit_ff <= 1'b0;
      end else if (item_take) begin
         mode_ff  <= mode_in;
         wlen_ff  <= wlen_in;
         accum_ff <= accum_in;
         pend_ff  <= pend_in;
         digit_ff <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && ch_we) begin
         chars_ff[ch_idx] <= b;
      end
   end

endmodule
`default_nettype wire

>>> hdl/pl0ts_rspq.sv
`default_nettype none
module pl0ts_rspq import pl0ts_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rspq_push_type rq_push,
   output logic               rq_room,
   input  wire logic          rsp_pop,
   output logic               rsp_empty,
   output rsp_rec_type        head
);

   localparam int PTR_W = $clog2(RQ_DEPTH);
   localparam int CNT_W = $clog2(RQ_DEPTH + 1);

   rsp_rec_type      ent_ff [RQ_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, wr_nx, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop_ok;

   assign rsp_empty = (cnt_ff == '0);
   assign head      = ent_ff[rd_ff];
   assign pop_ok    = rsp_pop && !rsp_empty;
   // room for the two beats one byte can make
   assign rq_room   = (cnt_ff <= CNT_W'(RQ_DEPTH - 2));
   assign wr_nx     = wr_ff + 1'b1;

   always_comb begin
      wr_in  = wr_ff + PTR_W'(rq_push.cnt);
      rd_in  = rd_ff + PTR_W'(pop_ok);
      cnt_in = cnt_ff + CNT_W'(rq_push.cnt) - CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RQ_DEPTH; i++) begin
         if (rq_push.cnt != 2'd0 && PTR_W'(i) == wr_ff) begin
            ent_ff[i] <= rq_push.rec0;
         end else if (rq_push.cnt == 2'd2 && PTR_W'(i) == wr_nx) begin
            ent_ff[i] <= rq_push.rec1;
         end
      end
   end

endmodule
`default_nettype wire

>>> hdl/pl0_token_scanner.sv
// pl0 token scanner: one byte per cycle in when not full, beats out via a 4-deep queue
// a byte is held in the input queue, scanned, and its beats written to the result queue
// throughput: one byte per cycle while results drain; bounded by the result pop rate,
// since a byte that closes one token and opens another gives two beats
// reset: synchronous, clears both queues and returns the scanner to idle at once
`default_nettype none
module pl0_token_scanner import pl0ts_pkg::*; #(
   parameter int NAME_CHARS    = NAME_CHARS_DEF,
   parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [5:0]       rsp_token_kind,
   output logic [2:0]       rsp_error_code,
   output logic [16:0]      rsp_number_value,
   output logic [63:0]      rsp_name_low,
   output logic [39:0]      rsp_name_high,
   output logic [3:0]       rsp_name_length,
   output logic             rsp_is_last
);

   logic          item_valid, item_take, rq_room;
   fq_item_type   item;
   rspq_push_type rq_push;
   rsp_rec_type   head;

   pl0ts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_text_byte (req_text_byte),
      .req_full      (req_full),
      .item_take     (item_take),
      .item_valid    (item_valid),
      .item          (item)
   );

   pl0ts_back #(
      .NAME_CHARS    (NAME_CHARS),
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rq_room    (rq_room),
      .rq_push    (rq_push)
   );

   pl0ts_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .rq_push   (rq_push),
      .rq_room   (rq_room),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .head      (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_error_code   = head.err;
   assign rsp_number_value = head.num;
   assign rsp_name_low     = head.lo;
   assign rsp_name_high    = head.hi;
   assign rsp_name_length  = head.len;
   assign rsp_is_last      = head.last;

endmodule
`default_nettype wire

>>> hdl/pl0ts_checker.sv
`default_nettype none
`include "pl0_token_scanner_macros.svh"
module pl0ts_checker import pl0ts_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [5:0]  rsp_token_kind,
   input wire logic [2:0]  rsp_error_code,
   input wire logic [16:0] rsp_number_value,
   input wire logic [63:0] rsp_name_low,
   input wire logic [39:0] rsp_name_high,
   input wire logic [3:0]  rsp_name_length,
   input wire logic        rsp_is_last
);

   // a waiting beat stays put until popped
   `PL0TS_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_token_kind) && $stable(rsp_is_last),
      "waiting result beat changed")

   // error beats carry no token
   `PL0TS_ASSERT_IMPL(a_err_kind, clock, reset, !rsp_empty && rsp_error_code != ERR_NONE,
      rsp_token_kind == TK_END, "error beat with a token kind")

   // name fields only on identifiers
   `PL0TS_ASSERT_IMPL(a_name_zero, clock, reset, !rsp_empty && rsp_token_kind != TK_IDENT,
      rsp_name_low == 64'd0 && rsp_name_high == 40'd0 && rsp_name_length == 4'd0,
      "name fields set on a non-identifier")

   // value only on numbers
   `PL0TS_ASSERT_IMPL(a_num_zero, clock, reset, !rsp_empty && rsp_token_kind != TK_NUMBER,
      rsp_number_value == 17'd0, "number value set on a non-number")

endmodule

bind pl0_token_scanner pl0ts_checker u_pl0ts_checker (.*);
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
   import pl0ts_pkg::*;

   // keyword token kinds
   localparam logic [5:0] TK_CONST     = 6'd1;
   localparam logic [5:0] TK_VAR       = 6'd2;
   localparam logic [5:0] TK_PROCEDURE = 6'd3;
   localparam logic [5:0] TK_BEGIN     = 6'd4;
   localparam logic [5:0] TK_END_KW    = 6'd5;
   localparam logic [5:0] TK_WHILE     = 6'd6;
   localparam logic [5:0] TK_DO        = 6'd7;
   localparam logic [5:0] TK_IF        = 6'd8;
   localparam logic [5:0] TK_THEN      = 6'd9;
   localparam logic [5:0] TK_ELSE      = 6'd10;
   localparam logic [5:0] TK_CALL      = 6'd11;
   localparam logic [5:0] TK_WRITE     = 6'd12;
   localparam logic [5:0] TK_READ      = 6'd13;
   localparam logic [5:0] TK_ODD       = 6'd28;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7f;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_PEND, SCAN_SLASH, SCAN_COMMENT, SCAN_HALT
   } scan_mode_e;

   typedef struct packed {
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [16:0] num;
      logic [63:0] name_lo;
      logic [39:0] name_hi;
      logic [3:0]  name_len;
      logic        last;
   } token_beat_t;

   typedef struct packed {
      logic [7:0]  text;
      logic        typed;
      logic [5:0]  kind;
      logic [2:0]  err;
      logic [16:0] num;
   } text_row_t;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_text_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [5:0]  rsp_token_kind;
   logic [2:0]  rsp_error_code;
   logic [16:0] rsp_number_value;
   logic [63:0] rsp_name_low;
   logic [39:0] rsp_name_high;
   logic [3:0]  rsp_name_length;
   logic        rsp_is_last;

   pl0_token_scanner i_dut (.*);

   string keyword_text [14] = '{"const", "var", "procedure", "begin", "end", "while", "do",
                                "if", "then", "else", "call", "write", "read", "odd"};
   logic [5:0] keyword_kind [14] = '{TK_CONST, TK_VAR, TK_PROCEDURE, TK_BEGIN, TK_END_KW,
                                     TK_WHILE, TK_DO, TK_IF, TK_THEN, TK_ELSE, TK_CALL,
                                     TK_WRITE, TK_READ, TK_ODD};
   string symbol_text [17] = '{"+", "-", "*", "%", "(", ")", ",", ".", ";", "<", ">", "/",
                               ":=", "==", "!=", "<=", ">="};
   logic [7:0] broken_symbol [20] = '{8'h22, 8'h23, 8'h24, 8'h26, 8'h27, 8'h3f, 8'h40,
                                      8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f, 8'h60, 8'h7b,
                                      8'h7c, 8'h7d, 8'h7e, CH_EQ, CH_COLON, CH_BANG};

   text_row_t opening_text [23] = '{
      '{CH_NUL,    1'b1, TK_END,    ERR_NONE,       17'd0},
      '{8'h39,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h39,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h39,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h39,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h39,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'hff,     1'b1, TK_NUMBER, ERR_NONE,       17'd99999},
      '{8'h31,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h61,     1'b1, TK_END,    ERR_BAD_IDENT,  17'd0},
      '{8'h24,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_NUL,    1'b1, TK_END,    ERR_NONE,       17'd0},
      '{CH_SLASH,  1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_SLASH,  1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h40,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_LF,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_LT,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_SLASH,  1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h5a,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_COLON,  1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_EQ,     1'b0, TK_END,    ERR_NONE,       17'd0},
      '{CH_BANG,   1'b0, TK_END,    ERR_NONE,       17'd0},
      '{8'h78,     1'b1, TK_END,    ERR_BAD_SYMBOL, 17'd0},
      '{CH_NUL,    1'b1, TK_END,    ERR_NONE,       17'd0}
   };

   // scanner state as the block should hold it
   scan_mode_e  scan_state = SCAN_IDLE;
   logic [7:0]  word_text [16];
   int          word_len = 0;
   logic [16:0] num_accum = '0;
   logic [7:0]  held_symbol = 8'h00;
   bit          digit_word = 1'b0;

   token_beat_t step_beats [$];
   token_beat_t token_backlog [$];
   logic [7:0]  source_text [$];
   int          burst_left = 0;
   int          error_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit is_digit_ch(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic bit is_alpha_ch(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
   endfunction

   function automatic bit is_punct_ch(input logic [7:0] b);
      return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
             (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
   endfunction

   function automatic void put_token(input logic [5:0] kind, input logic [2:0] err,
                                     input logic [16:0] num, input logic [63:0] lo,
                                     input logic [39:0] hi, input logic [3:0] len);
      step_beats.push_back(token_beat_t'{kind, err, num, lo, hi, len, 1'b0});
   endfunction

   function automatic void put_mark(input logic [5:0] kind);
      put_token(kind, ERR_NONE, '0, '0, '0, '0);
   endfunction

   function automatic void halt_on(input logic [2:0] err, input logic [7:0] b);
      put_token(TK_END, err, '0, '0, '0, '0);
      scan_state = SCAN_HALT;
      if (b == CH_NUL) begin
         put_mark(TK_END);
         scan_state = SCAN_IDLE;
      end
   endfunction

   function automatic void open_word(input logic [7:0] b);
      foreach (word_text[i]) word_text[i] = 8'h00;
      word_text[0] = b;
      word_len = 1;
      digit_word = is_digit_ch(b);
      num_accum = digit_word ? 17'(b - CH_0) : 17'd0;
      scan_state = SCAN_WORD;
   endfunction

   function automatic void extend_word(input logic [7:0] b);
      if (digit_word) begin
         if (word_len >= NUMBER_DIGITS_DEF) begin
            halt_on(ERR_LONG_NUMBER, b);
         end else if (is_alpha_ch(b)) begin
            halt_on(ERR_BAD_IDENT, b);
         end else begin
            num_accum = 17'(int'(num_accum) * 10 + int'(b - CH_0));
            word_len++;
         end
      end else begin
         if (word_len < 16) word_text[word_len] = b;
         if (word_len <= 16) word_len++;
      end
   endfunction

   function automatic bit match_keyword(output logic [5:0] kind);
      string w;
      bit    hit;
      kind = TK_END;
      for (int k = 0; k < 14; k++) begin
         w = keyword_text[k];
         hit = (w.len() == word_len);
         for (int i = 0; i < w.len() && hit; i++) begin
            if (w[i] != word_text[i]) hit = 1'b0;
         end
         if (hit) begin
            kind = keyword_kind[k];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // returns zero when the word turns out too long
   function automatic bit close_word(input logic [7:0] b);
      logic [63:0] lo;
      logic [39:0] hi;
      logic [5:0]  kind;
      lo = '0;
      hi = '0;
      scan_state = SCAN_IDLE;
      if (digit_word) begin
         put_token(TK_NUMBER, ERR_NONE, num_accum, '0, '0, '0);
         return 1'b1;
      end
      if (match_keyword(kind)) begin
         put_mark(kind);
         return 1'b1;
      end
      if (word_len > NAME_CHARS_DEF) begin
         halt_on(ERR_LONG_IDENT, b);
         return 1'b0;
      end
      for (int k = 0; k < word_len && k < 13; k++) begin
         if (k < 8) lo[k*8 +: 8] = word_text[k];
         else hi[(k-8)*8 +: 8] = word_text[k];
      end
      put_token(TK_IDENT, ERR_NONE, '0, lo, hi, 4'(word_len));
      return 1'b1;
   endfunction

   function automatic void start_token(input logic [7:0] b);
      scan_state = SCAN_IDLE;
      if (b == CH_NUL) begin
         put_mark(TK_END);
      end else if (is_digit_ch(b) || is_alpha_ch(b)) begin
         open_word(b);
      end else if (is_punct_ch(b)) begin
         case (b)
            CH_EQ, CH_LT, CH_GT, CH_COLON, CH_BANG: begin
               held_symbol = b;
               scan_state = SCAN_PEND;
            end
            CH_SLASH:  scan_state = SCAN_SLASH;
            CH_PLUS:   put_mark(TK_PLUS);
            CH_MINUS:  put_mark(TK_MINUS);
            CH_STAR:   put_mark(TK_TIMES);
            CH_PCT:    put_mark(TK_MOD);
            CH_LPAREN: put_mark(TK_LPAREN);
            CH_RPAREN: put_mark(TK_RPAREN);
            CH_COMMA:  put_mark(TK_COMMA);
            CH_PERIOD: put_mark(TK_PERIOD);
            CH_SEMI:   put_mark(TK_SEMI);
            default:   halt_on(ERR_BAD_SYMBOL, b);
         endcase
      end
   endfunction

   // tokens caused by one source byte land in step_beats
   function automatic void scan_byte(input logic [7:0] b);
      logic [5:0] kind;
      step_beats.delete();
      case (scan_state)
         SCAN_HALT, SCAN_COMMENT: begin
            if (b == CH_NUL) begin
               put_mark(TK_END);
               scan_state = SCAN_IDLE;
            end else if (scan_state == SCAN_COMMENT && b == CH_LF) begin
               scan_state = SCAN_IDLE;
            end
         end
         SCAN_SLASH: begin
            if (b == CH_SLASH) begin
               scan_state = SCAN_COMMENT;
            end else begin
               put_mark(TK_SLASH);
               start_token(b);
            end
         end
         SCAN_PEND: begin
            if (b == CH_EQ) begin
               case (held_symbol)
                  CH_COLON: kind = TK_BECOMES;
                  CH_EQ:    kind = TK_EQL;
                  CH_BANG:  kind = TK_NEQ;
                  CH_LT:    kind = TK_LEQ;
                  default:  kind = TK_GEQ;
               endcase
               put_mark(kind);
               scan_state = SCAN_IDLE;
            end else if (held_symbol == CH_LT || held_symbol == CH_GT) begin
               put_mark(held_symbol == CH_LT ? TK_LSS : TK_GTR);
               start_token(b);
            end else begin
               halt_on(ERR_BAD_SYMBOL, b);
            end
            // cleared even when start_token just held a new symbol
            held_symbol = 8'h00;
         end
         SCAN_WORD: begin
            if (is_digit_ch(b) || is_alpha_ch(b)) extend_word(b);
            else if (close_word(b)) start_token(b);
         end
         default: start_token(b);
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_alnum();
      return ($urandom_range(0, 3) == 0) ? 8'(CH_0 + $urandom_range(0, 9)) : rand_letter();
   endfunction

   function automatic logic [7:0] rand_separator();
      case ($urandom_range(0, 5))
         0: return CH_TAB;
         1: return CH_LF;
         2: return CH_CR;
         3: return CH_DEL;
         4: return 8'($urandom_range(128, 255));
         default: return CH_SPACE;
      endcase
   endfunction

   // mostly well-formed source text with some noise, ended by a nul
   task automatic compose_program();
      int    pick;
      int    n;
      string w;
      source_text.delete();
      repeat ($urandom_range(4, 40)) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            w = keyword_text[$urandom_range(0, 13)];
            for (int i = 0; i < w.len(); i++) begin
               source_text.push_back(($urandom_range(0, 19) == 0) ? (w[i] ^ 8'h20) : w[i]);
            end
         end else if (pick < 40) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 13);
            source_text.push_back(rand_letter());
            repeat (n - 1) source_text.push_back(rand_alnum());
         end else if (pick < 55) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
            repeat (n) source_text.push_back(8'(CH_0 + $urandom_range(0, 9)));
            if ($urandom_range(0, 19) == 0) source_text.push_back(rand_letter());
         end else if (pick < 80) begin
            w = symbol_text[$urandom_range(0, 16)];
            for (int i = 0; i < w.len(); i++) source_text.push_back(w[i]);
         end else if (pick < 87) begin
            source_text.push_back(CH_SLASH);
            source_text.push_back(CH_SLASH);
            repeat ($urandom_range(0, 12)) source_text.push_back(8'($urandom_range(32, 126)));
            if ($urandom_range(0, 3) != 0) source_text.push_back(CH_LF);
         end else if (pick < 95) begin
            source_text.push_back(8'($urandom_range(1, 255)));
         end else begin
            source_text.push_back(broken_symbol[$urandom_range(0, 19)]);
         end
         if ($urandom_range(0, 9) < 7) source_text.push_back(rand_separator());
      end
      source_text.push_back(CH_NUL);
   endtask

   task automatic feed_byte(input logic [7:0] b, input logic typed, input logic [5:0] kind,
                            input logic [2:0] err, input logic [16:0] num);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 160);
         end else begin
            burst_left = $urandom_range(1, 12);
            req_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_full);
      scan_byte(b);
      if (typed) begin
         token_backlog.push_back(token_beat_t'{kind, err, num, 64'd0, 40'd0, 4'd0, 1'b1});
      end else begin
         foreach (step_beats[i]) token_backlog.push_back(step_beats[i]);
      end
   endtask

   function automatic void compare_beat();
      token_beat_t want;
      if (token_backlog.size() == 0) begin
         $error("unexpected beat: token_kind %0d error_code %0d", rsp_token_kind,
                rsp_error_code);
         error_count++;
         return;
      end
      want = token_backlog.pop_front();
      if (rsp_token_kind !== want.kind) begin
         $error("token_kind: expected %0d, got %0d", want.kind, rsp_token_kind);
         error_count++;
      end
      if (rsp_error_code !== want.err) begin
         $error("error_code: expected %0d, got %0d", want.err, rsp_error_code);
         error_count++;
      end
      if (rsp_number_value !== want.num) begin
         $error("number_value: expected %0d, got %0d", want.num, rsp_number_value);
         error_count++;
      end
      if (rsp_name_low !== want.name_lo) begin
         $error("name_low: expected %h, got %h", want.name_lo, rsp_name_low);
         error_count++;
      end
      if (rsp_name_high !== want.name_hi) begin
         $error("name_high: expected %h, got %h", want.name_hi, rsp_name_high);
         error_count++;
      end
      if (rsp_name_length !== want.name_len) begin
         $error("name_length: expected %0d, got %0d", want.name_len, rsp_name_length);
         error_count++;
      end
      if (rsp_is_last !== want.last) begin
         $error("is_last: expected %0d, got %0d", want.last, rsp_is_last);
         error_count++;
      end
   endfunction

   // receiver: checks popped beats; the pop pattern is redrawn at random, periodically
   initial begin : drain
      int unsigned pop_cycle;
      int          stall_mode;
      pop_cycle = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) compare_beat();
         if (pop_cycle % 192 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= (pop_cycle % 5) < 3;
            2: rsp_pop <= 1'($urandom_range(0, 1));
            default: rsp_pop <= ($urandom_range(0, 7) == 0);
         endcase
         pop_cycle++;
      end
   end

   initial begin : feed
      int random_bytes;
      random_bytes = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_text[i]) begin
         feed_byte(opening_text[i].text, opening_text[i].typed, opening_text[i].kind,
                   opening_text[i].err, opening_text[i].num);
      end
      while (random_bytes < 1300) begin
         compose_program();
         foreach (source_text[i]) feed_byte(source_text[i], 1'b0, TK_END, ERR_NONE, '0);
         random_bytes += source_text.size();
      end
      req_push <= 1'b0;
      while (token_backlog.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/pl0ts_pkg.sv
hdl/pl0ts_front.sv
hdl/pl0ts_back.sv
hdl/pl0ts_rspq.sv
hdl/pl0_token_scanner.sv
hdl/pl0ts_checker.sv
bench/tb.sv
